FILE: rtl/lbpc_pkg.sv
// Package: shared types and fixed constants of the LED blink pattern controller.
`default_nettype none
package lbpc_pkg;

  // Confirmation sequence: CONFIRM_COUNT on/off pairs, each phase CONFIRM_PERIOD_MS long.
  localparam int unsigned CONFIRM_COUNT     = 3;
  localparam int unsigned CONFIRM_PERIOD_MS = 80;
  localparam int unsigned CONFIRM_STEPS     = 2 * CONFIRM_COUNT;
  localparam logic [31:0] CONFIRM_TOTAL_MS  = 32'(CONFIRM_STEPS * CONFIRM_PERIOD_MS);

  // Register file geometry
  localparam int unsigned ADDR_W = 4;

  // Config register reset values
  localparam logic [15:0] ON_TIME_RST     = 16'd150;
  localparam logic [15:0] OFF_TIME_RST    = 16'd150;
  localparam logic [15:0] PAUSE_TIME_RST  = 16'd800;
  localparam logic [3:0]  BLINK_COUNT_RST = 4'd1;

  typedef enum logic [1:0] {
    REG_ON_TIME     = 2'd0,
    REG_OFF_TIME    = 2'd1,
    REG_PAUSE_TIME  = 2'd2,
    REG_BLINK_COUNT = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [15:0] on_time_ms;
    logic [15:0] off_time_ms;
    logic [15:0] pause_time_ms;
    logic [3:0]  blink_count;
  } cfg_t;

  typedef struct packed {
    logic        pattern_running;
    logic [3:0]  blink_index;
    logic        phase_lit;
    logic [31:0] last_change_ms;
    logic        confirm_running;
    logic [31:0] confirm_begin_ms;
    logic        led2_level;
  } state_t;

  typedef struct packed {
    logic led1_on;
    logic led2_on;
    logic confirm_busy;
  } result_t;

endpackage
`default_nettype wire

FILE: rtl/lbpc_if.sv
// Interfaces: input and result item channels (valid/ready with payload).
`default_nettype none
interface lbpc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_ms;
  logic        bypass;
  logic        start_confirm;

  modport source (output valid, output now_ms, output bypass, output start_confirm,
                  input ready);
  modport sink   (input valid, input now_ms, input bypass, input start_confirm,
                  output ready);
endinterface

interface lbpc_out_if;
  logic valid;
  logic ready;
  logic led1_on;
  logic led2_on;
  logic confirm_busy;

  modport source (output valid, output led1_on, output led2_on, output confirm_busy,
                  input ready);
  modport sink   (input valid, input led1_on, input led2_on, input confirm_busy,
                  output ready);
endinterface
`default_nettype wire

FILE: rtl/lbpc_step.sv
// Step logic: next state and result of one service pass.
`default_nettype none
module lbpc_step (
  input  lbpc_pkg::state_t  st_i,
  input  lbpc_pkg::cfg_t    cfg_i,
  input  logic [31:0]       now_ms_i,
  input  logic              bypass_i,
  input  logic              start_confirm_i,
  output lbpc_pkg::state_t  st_o,
  output lbpc_pkg::result_t res_o
);
  import lbpc_pkg::*;

  logic [31:0] begin_ms;
  logic [31:0] conf_elapsed;
  logic [31:0] pat_elapsed;
  logic [CONFIRM_STEPS-2:0] step_ge;
  logic        conf_done;
  logic        conf_lvl;

  // Confirm start is folded in before timing
  assign begin_ms     = start_confirm_i ? now_ms_i : st_i.confirm_begin_ms;
  assign conf_elapsed = now_ms_i - begin_ms;
  assign conf_done    = conf_elapsed >= CONFIRM_TOTAL_MS;

  // Period boundaries crossed; parity gives the step's odd/even phase
  for (genvar k = 1; k < CONFIRM_STEPS; k++) begin : g_bound
    assign step_ge[k-1] = conf_elapsed >= 32'(k * CONFIRM_PERIOD_MS);
  end
  assign conf_lvl = ~(^step_ge);

  always_comb begin
    st_o = st_i;
    res_o.led1_on      = ~bypass_i;
    res_o.confirm_busy = 1'b0;
    pat_elapsed        = '0;

    if (start_confirm_i) begin
      st_o.confirm_running  = 1'b1;
      st_o.confirm_begin_ms = now_ms_i;
    end

    if (st_o.confirm_running) begin
      if (conf_done) begin
        st_o.confirm_running = 1'b0;
        st_o.led2_level      = 1'b0;
        st_o.pattern_running = 1'b0;
      end else begin
        res_o.led1_on      = conf_lvl;
        st_o.led2_level    = conf_lvl;
        res_o.confirm_busy = 1'b1;
      end
    end

    if (!res_o.confirm_busy) begin
      pat_elapsed = now_ms_i - st_o.last_change_ms;
      if (bypass_i) begin
        if (st_o.pattern_running) begin
          st_o.pattern_running = 1'b0;
          st_o.led2_level      = 1'b0;
        end
      end else if (!st_o.pattern_running) begin
        // pattern start: dark, no timing decision this pass
        st_o.pattern_running = 1'b1;
        st_o.blink_index     = '0;
        st_o.phase_lit       = 1'b0;
        st_o.last_change_ms  = now_ms_i;
        st_o.led2_level      = 1'b0;
      end else if (st_o.phase_lit) begin
        if (pat_elapsed >= {16'd0, cfg_i.on_time_ms}) begin
          st_o.led2_level     = 1'b0;
          st_o.phase_lit      = 1'b0;
          st_o.last_change_ms = now_ms_i;
          st_o.blink_index    = st_o.blink_index + 4'd1;
        end
      end else if (st_o.blink_index >= cfg_i.blink_count) begin
        if (pat_elapsed >= {16'd0, cfg_i.pause_time_ms}) begin
          st_o.blink_index    = '0;
          st_o.phase_lit      = 1'b0;
          st_o.last_change_ms = now_ms_i;
        end
      end else if (pat_elapsed >= {16'd0, cfg_i.off_time_ms}) begin
        st_o.led2_level     = 1'b1;
        st_o.phase_lit      = 1'b1;
        st_o.last_change_ms = now_ms_i;
      end
    end

    res_o.led2_on = st_o.led2_level;
  end

endmodule
`default_nettype wire

FILE: rtl/led_blink_pattern_controller.sv
// Top level: LED blink pattern controller with item channels and APB config.
//
// Usage:
//   in_ch_i  carries one service tick per item: now_ms (free-running ms time),
//            bypass and start_confirm. Each item yields exactly one result.
//   out_ch_o carries led1_on, led2_on and confirm_busy for that tick.
//   APB port writes on/off/pause times (regs 0..2, 16 bit) and blink_count
//   (reg 3, 4 bit) at byte addresses 0, 4, 8, 12; pready is tied high.
//   Write config only while no items are in flight.
// Path: an accepted item goes into the input register, then through the
//   single-pass step logic into the result register.
// Throughput: one item per cycle while out_ch_o.ready stays high; the step logic
//   is one compare-and-update pass, and the state register feeds straight back.
// Reset: LED2 level cleared, pattern and confirm idle, config at defaults
//   (150/150/800 ms, one blink). No clearing pass is needed.
// Stall: while the result waits on out_ch_o.ready the input register still
//   takes one more item; after that in_ch_i.ready drops until the result
//   register drains. Nothing is dropped or repeated.
`default_nettype none
module led_blink_pattern_controller (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  lbpc_in_if.sink                        in_ch_i,
  lbpc_out_if.source                     out_ch_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lbpc_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import lbpc_pkg::*;

  // config registers
  cfg_t     cfg_q;
  reg_idx_e reg_idx;
  logic     cfg_wr;

  // input register stage
  logic        s1_valid_q;
  logic [31:0] s1_now_q;
  logic        s1_bypass_q;
  logic        s1_start_q;
  logic        s1_adv;

  // step state and result register
  state_t  state_q, state_d;
  result_t res_d, res_q;
  logic    out_valid_q;
  logic    out_free;

  // ---------------- APB config ----------------
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    unique case (reg_idx)
      REG_ON_TIME:     prdata = {16'd0, cfg_q.on_time_ms};
      REG_OFF_TIME:    prdata = {16'd0, cfg_q.off_time_ms};
      REG_PAUSE_TIME:  prdata = {16'd0, cfg_q.pause_time_ms};
      REG_BLINK_COUNT: prdata = {28'd0, cfg_q.blink_count};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.on_time_ms    <= ON_TIME_RST;
      cfg_q.off_time_ms   <= OFF_TIME_RST;
      cfg_q.pause_time_ms <= PAUSE_TIME_RST;
      cfg_q.blink_count   <= BLINK_COUNT_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_ON_TIME:     cfg_q.on_time_ms    <= pwdata[15:0];
        REG_OFF_TIME:    cfg_q.off_time_ms   <= pwdata[15:0];
        REG_PAUSE_TIME:  cfg_q.pause_time_ms <= pwdata[15:0];
        REG_BLINK_COUNT: cfg_q.blink_count   <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // ---------------- handshake ----------------
  // Result register frees when empty or being taken; the input register
  // moves forward whenever the result register can take it.
  assign out_free      = !out_valid_q || out_ch_o.ready;
  assign s1_adv        = s1_valid_q && out_free;
  assign in_ch_i.ready = !s1_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ch_i.ready) begin
      s1_valid_q <= in_ch_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch_i.valid && in_ch_i.ready) begin
      s1_now_q    <= in_ch_i.now_ms;
      s1_bypass_q <= in_ch_i.bypass;
      s1_start_q  <= in_ch_i.start_confirm;
    end
  end

  // ---------------- service pass ----------------
  lbpc_step u_step (
    .st_i            (state_q),
    .cfg_i           (cfg_q),
    .now_ms_i        (s1_now_q),
    .bypass_i        (s1_bypass_q),
    .start_confirm_i (s1_start_q),
    .st_o            (state_d),
    .res_o           (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (s1_adv) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      res_q <= res_d;
    end
  end

  assign out_ch_o.valid        = out_valid_q;
  assign out_ch_o.led1_on      = res_q.led1_on;
  assign out_ch_o.led2_on      = res_q.led2_on;
  assign out_ch_o.confirm_busy = res_q.confirm_busy;

  // ---------------- assertions ----------------
  // During confirmation both LEDs blink together
  a_confirm_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.confirm_busy |-> res_q.led1_on == res_q.led2_on)
    else $error("confirm blink: LEDs out of step");

  // Bypassed and not confirming: preset LED must be dark
  a_bypass_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !res_q.confirm_busy && !res_q.led1_on |-> !res_q.led2_on)
    else $error("preset LED lit while bypassed");

  // Preset LED level only held while the pattern or the confirmation runs
  a_led2_needs_pattern: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !state_q.pattern_running |-> !state_q.led2_level || state_q.confirm_running)
    else $error("LED2 lit with pattern stopped");

  // A held input item stays put until it moves on
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_free |=> s1_valid_q && $stable(s1_now_q))
    else $error("input register lost a stalled item");

endmodule
`default_nettype wire
